>>> rtl/mseu_pkg.sv
// Package with the operation codes, status codes and result type of the execute unit.
package mseu_pkg;

    localparam int DATA_W     = 32;
    localparam int LINE_W     = 12;
    localparam int REG_COUNT  = 32;
    localparam int REG_AW     = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Registers that the assembler reserves and the unit refuses.
    localparam logic [REG_AW-1:0] REG_AT = 5'd1;
    localparam logic [REG_AW-1:0] REG_K0 = 5'd26;
    localparam logic [REG_AW-1:0] REG_K1 = 5'd27;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_ADD       = 4'd1,
        OP_SUB       = 4'd2,
        OP_MUL       = 4'd3,
        OP_SLT       = 4'd4,
        OP_ADDI      = 4'd5,
        OP_LA        = 4'd6,
        OP_LW_LABEL  = 4'd7,
        OP_SW_LABEL  = 4'd8,
        OP_LW_OFFSET = 4'd9,
        OP_SW_OFFSET = 4'd10,
        OP_BNE       = 4'd11,
        OP_J         = 4'd12,
        OP_HALT      = 4'd13,
        OP_INVALID   = 4'd14
    } op_t;

    typedef enum logic [1:0] {
        STATUS_CONTINUE = 2'd0,
        STATUS_HALT     = 2'd1,
        STATUS_ERROR    = 2'd2
    } status_t;

    typedef struct packed {
        logic              redirect;
        logic [LINE_W-1:0] redirect_line;
        logic [DATA_W-1:0] written_value;
        status_t           status;
    } result_t;

endpackage

>>> rtl/mseu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mseu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/mips_subset_execute_unit.sv
// Top level of the execute unit: register file and data memory pipeline with a result queue.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-------------------------------------
//  instr    | in        | instr_valid / instr_stall   | operation .. label_address
//  result   | out       | result_valid / result_stall | redirect, redirect_line, written_value,
//           |           |                             | status
//
// One request is taken per cycle while instr_stall is low. The pipeline is register read,
// execute with data memory access, write back into a four-entry result queue; the register
// file write back is forwarded to younger requests. After reset the data memory is cleared,
// all DATA_WORDS words of it, while instr_stall is high. instr_stall also rises when four
// requests are in flight, accepted but not yet taken from the result queue.
module mips_subset_execute_unit #(
    parameter int DATA_WORDS = 1024,
    parameter int LINE_BITS  = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               instr_valid,
    output logic               instr_stall,
    input  logic [3:0]         operation,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         source_reg,
    input  logic [4:0]         second_reg,
    input  logic signed [31:0] immediate,
    input  logic [11:0]        branch_target,
    input  logic [11:0]        label_address,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               redirect,
    output logic [11:0]        redirect_line,
    output logic signed [31:0] written_value,
    output logic [1:0]         status
);

    import mseu_pkg::*;

    localparam int DMEM_AW = $clog2(DATA_WORDS);

    logic accept;
    logic pop;

    // Data memory clearing after reset.
    logic               clear_active_reg;
    logic [DMEM_AW-1:0] clear_addr_reg;

    // Register file read stage.
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [REG_AW-1:0]    rd_b_addr;
    logic [DATA_W-1:0]    rf_a_rdata;
    logic [DATA_W-1:0]    rf_b_rdata;

    // Execute stage.
    logic              s1_valid_reg;
    logic [3:0]        s1_op_reg;
    logic [REG_AW-1:0] s1_d_reg;
    logic [REG_AW-1:0] s1_s_reg;
    logic [REG_AW-1:0] s1_t_reg;
    logic [DATA_W-1:0] s1_imm_reg;
    logic [LINE_W-1:0] s1_tgt_reg;
    logic [LINE_W-1:0] s1_lab_reg;
    logic              s1_a_valid_reg;
    logic              s1_b_valid_reg;

    logic [REG_AW-1:0] s1_b_addr;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] alu;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] lab_ext;
    logic [DATA_W-1:0] eff_addr;
    logic              addr_ok;
    logic              tgt_bad;
    logic              bad_d;
    logic              bad_s;
    logic              bad_t;
    logic              ex_err;
    logic              ex_halt;
    logic              ex_redirect;
    logic [LINE_W-1:0] ex_line;
    logic              ex_we;
    logic              ex_load;
    logic [DATA_W-1:0] ex_val;
    logic              ex_store;

    logic               dmem_we;
    logic [DMEM_AW-1:0] dmem_waddr;
    logic [DATA_W-1:0]  dmem_wdata;
    logic [DATA_W-1:0]  dmem_rdata;

    // Write back stage.
    logic              s2_valid_reg;
    logic              s2_we_reg;
    logic              s2_load_reg;
    logic [REG_AW-1:0] s2_waddr_reg;
    logic [DATA_W-1:0] s2_val_reg;
    logic              s2_redirect_reg;
    logic [LINE_W-1:0] s2_line_reg;
    status_t           s2_status_reg;
    logic [DATA_W-1:0] s2_wdata;
    logic              rf_we;

    // Last register file write, for requests whose read raced it.
    logic              wb_we_reg;
    logic [REG_AW-1:0] wb_addr_reg;
    logic [DATA_W-1:0] wb_data_reg;

    // Result queue.
    result_t               fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_count_reg;
    logic [FIFO_CNT_W-1:0] inflight_reg;
    logic [FIFO_CNT_W-1:0] inflight_next;
    result_t               head;

    assign instr_stall = clear_active_reg || (inflight_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign accept      = instr_valid && !instr_stall;
    assign result_valid = (fifo_count_reg != '0);
    assign pop          = result_valid && !result_stall;

    // Port B reads the stored or compared register for stores and bne.
    assign rd_b_addr = ((op_t'(operation) == OP_SW_LABEL) || (op_t'(operation) == OP_SW_OFFSET)
                        || (op_t'(operation) == OP_BNE)) ? dest_reg : second_reg;

    mseu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_waddr_reg),
        .wdata (s2_wdata),
        .raddr (source_reg),
        .rdata (rf_a_rdata)
    );

    mseu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_waddr_reg),
        .wdata (s2_wdata),
        .raddr (rd_b_addr),
        .rdata (rf_b_rdata)
    );

    mseu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DATA_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (dmem_we),
        .waddr (dmem_waddr),
        .wdata (dmem_wdata),
        .raddr (eff_addr[DMEM_AW+1:2]),
        .rdata (dmem_rdata)
    );

    // ---------------------------------------------------------------- clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == DMEM_AW'(DATA_WORDS - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg      <= operation;
        s1_d_reg       <= dest_reg;
        s1_s_reg       <= source_reg;
        s1_t_reg       <= second_reg;
        s1_imm_reg     <= immediate;
        s1_tgt_reg     <= branch_target;
        s1_lab_reg     <= label_address;
        s1_a_valid_reg <= rf_valid_reg[source_reg];
        s1_b_valid_reg <= rf_valid_reg[rd_b_addr];
    end

    // ---------------------------------------------------------------- execute stage
    assign s1_b_addr = ((op_t'(s1_op_reg) == OP_SW_LABEL) || (op_t'(s1_op_reg) == OP_SW_OFFSET)
                        || (op_t'(s1_op_reg) == OP_BNE)) ? s1_d_reg : s1_t_reg;

    // A load's value is still on the data memory output while it sits in write back.
    assign s2_wdata = s2_load_reg ? dmem_rdata : s2_val_reg;

    always_comb
    begin
        if (s2_valid_reg && s2_we_reg && (s2_waddr_reg == s1_s_reg))
        begin
            opa = s2_wdata;
        end
        else if (wb_we_reg && (wb_addr_reg == s1_s_reg))
        begin
            opa = wb_data_reg;
        end
        else
        begin
            opa = s1_a_valid_reg ? rf_a_rdata : '0;
        end
    end

    always_comb
    begin
        if (s2_valid_reg && s2_we_reg && (s2_waddr_reg == s1_b_addr))
        begin
            opb = s2_wdata;
        end
        else if (wb_we_reg && (wb_addr_reg == s1_b_addr))
        begin
            opb = wb_data_reg;
        end
        else
        begin
            opb = s1_b_valid_reg ? rf_b_rdata : '0;
        end
    end

    assign prod    = opa * opb;
    assign lab_ext = {{(DATA_W - LINE_W){1'b0}}, s1_lab_reg};
    assign bad_d   = (s1_d_reg == REG_AT) || (s1_d_reg == REG_K0) || (s1_d_reg == REG_K1);
    assign bad_s   = (s1_s_reg == REG_AT) || (s1_s_reg == REG_K0) || (s1_s_reg == REG_K1);
    assign bad_t   = (s1_t_reg == REG_AT) || (s1_t_reg == REG_K0) || (s1_t_reg == REG_K1);
    assign tgt_bad = (s1_tgt_reg == '0)
                     || ((LINE_BITS < LINE_W) && ((s1_tgt_reg >> LINE_BITS) != '0));

    always_comb
    begin
        case (op_t'(s1_op_reg))
            OP_LW_OFFSET, OP_SW_OFFSET: eff_addr = s1_imm_reg + opa;
            default:                    eff_addr = lab_ext;
        endcase
    end

    assign addr_ok = (eff_addr[1:0] == 2'b00)
                     && (eff_addr[DATA_W-1:2] < (DATA_W - 2)'(DATA_WORDS));

    always_comb
    begin
        case (op_t'(s1_op_reg))
            OP_ADD:  alu = opa + opb;
            OP_SUB:  alu = opa - opb;
            OP_MUL:  alu = prod;
            OP_SLT:  alu = {{(DATA_W - 1){1'b0}}, ($signed(opa) < $signed(opb))};
            OP_ADDI: alu = opa + s1_imm_reg;
            default: alu = lab_ext;
        endcase
    end

    always_comb
    begin
        ex_err      = 1'b0;
        ex_halt     = 1'b0;
        ex_redirect = 1'b0;
        ex_line     = '0;
        ex_we       = 1'b0;
        ex_load     = 1'b0;
        ex_val      = '0;
        ex_store    = 1'b0;
        case (op_t'(s1_op_reg))
            OP_NONE:
            begin
            end
            OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI, OP_LA:
            begin
                if (bad_d
                    || ((op_t'(s1_op_reg) != OP_LA) && bad_s)
                    || ((op_t'(s1_op_reg) != OP_LA) && (op_t'(s1_op_reg) != OP_ADDI) && bad_t)
                    || ((op_t'(s1_op_reg) == OP_LA) && (s1_lab_reg == '0)))
                begin
                    ex_err = 1'b1;
                end
                else if (s1_d_reg != '0)
                begin
                    ex_we  = 1'b1;
                    ex_val = alu;
                end
            end
            OP_LW_LABEL, OP_SW_LABEL, OP_LW_OFFSET, OP_SW_OFFSET:
            begin
                if (bad_d || !addr_ok
                    || (((op_t'(s1_op_reg) == OP_LW_LABEL) || (op_t'(s1_op_reg) == OP_SW_LABEL))
                        && (s1_lab_reg == '0))
                    || (((op_t'(s1_op_reg) == OP_LW_OFFSET) || (op_t'(s1_op_reg) == OP_SW_OFFSET))
                        && (bad_s || (s1_imm_reg[1:0] != 2'b00))))
                begin
                    ex_err = 1'b1;
                end
                else if ((op_t'(s1_op_reg) == OP_SW_LABEL) || (op_t'(s1_op_reg) == OP_SW_OFFSET))
                begin
                    ex_store = 1'b1;
                    ex_val   = opb;
                end
                else if (s1_d_reg != '0)
                begin
                    ex_we   = 1'b1;
                    ex_load = 1'b1;
                end
            end
            OP_BNE:
            begin
                if (bad_d || bad_s || tgt_bad)
                begin
                    ex_err = 1'b1;
                end
                else if (opa != opb)
                begin
                    ex_redirect = 1'b1;
                    ex_line     = s1_tgt_reg;
                end
            end
            OP_J:
            begin
                if (tgt_bad)
                begin
                    ex_err = 1'b1;
                end
                else
                begin
                    ex_redirect = 1'b1;
                    ex_line     = s1_tgt_reg;
                end
            end
            OP_HALT:
            begin
                ex_halt = 1'b1;
            end
            default:
            begin
                ex_err = 1'b1;
            end
        endcase
    end

    assign dmem_we    = clear_active_reg || (s1_valid_reg && ex_store);
    assign dmem_waddr = clear_active_reg ? clear_addr_reg : eff_addr[DMEM_AW+1:2];
    assign dmem_wdata = clear_active_reg ? '0 : ex_val;

    // ---------------------------------------------------------------- write back stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_we_reg    <= 1'b0;
            wb_we_reg    <= 1'b0;
            rf_valid_reg <= '0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_we_reg    <= s1_valid_reg && ex_we;
            wb_we_reg    <= rf_we;
            if (rf_we)
            begin
                rf_valid_reg[s2_waddr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_load_reg     <= ex_load;
        s2_waddr_reg    <= s1_d_reg;
        s2_val_reg      <= ex_val;
        s2_redirect_reg <= ex_redirect;
        s2_line_reg     <= ex_line;
        s2_status_reg   <= ex_err ? STATUS_ERROR : (ex_halt ? STATUS_HALT : STATUS_CONTINUE);
        wb_addr_reg     <= s2_waddr_reg;
        wb_data_reg     <= s2_wdata;
    end

    assign rf_we = s2_valid_reg && s2_we_reg;

    // ---------------------------------------------------------------- result queue
    assign inflight_next = inflight_reg + FIFO_CNT_W'(accept) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            inflight_reg   <= '0;
        end
        else
        begin
            inflight_reg   <= inflight_next;
            fifo_count_reg <= fifo_count_reg + FIFO_CNT_W'(s2_valid_reg) - FIFO_CNT_W'(pop);
            if (s2_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            fifo_mem_reg[wr_ptr_reg] <= '{redirect:      s2_redirect_reg,
                                          redirect_line: s2_line_reg,
                                          written_value: s2_wdata,
                                          status:        s2_status_reg};
        end
    end

    assign head          = fifo_mem_reg[rd_ptr_reg];
    assign redirect      = head.redirect;
    assign redirect_line = head.redirect_line;
    assign written_value = head.written_value;
    assign status        = head.status;

endmodule

>>> test/exec_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class holding the expected behavior of the execute unit and its result checks.
package exec_scoreboard_pkg;

    import mseu_pkg::*;

    localparam int MEM_WORDS = 1024;

    // Operation code 15 has no name in the design package; it must be refused.
    localparam logic [3:0] OP_UNDEFINED = 4'd15;

    class exec_scoreboard;

        logic [31:0] regs [REG_COUNT];
        logic [31:0] mem [MEM_WORDS];
        result_t     expected_results [$];
        int unsigned fail_count;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            foreach (mem[i])
                mem[i] = '0;
            fail_count = 0;
        endfunction

        function bit is_reserved(logic [4:0] r);
            return r == REG_AT || r == REG_K0 || r == REG_K1;
        endfunction

        function logic [31:0] read_reg(logic [4:0] r);
            return (r == 5'd0) ? 32'd0 : regs[r];
        endfunction

        function logic [31:0] write_reg(logic [4:0] r, logic [31:0] v);
            if (r == 5'd0)
                return 32'd0;
            regs[r] = v;
            return v;
        endfunction

        function bit word_ok(logic [31:0] a);
            return a[1:0] == 2'b00 && a < MEM_WORDS * 4;
        endfunction

        // Runs one instruction against the shadow register file and memory.
        function result_t execute_instruction(logic [3:0] op, logic [4:0] d, logic [4:0] s,
                                              logic [4:0] t, logic [31:0] imm,
                                              logic [11:0] tgt, logic [11:0] lab);
            result_t     r;
            logic [31:0] a;
            logic [31:0] x;
            logic [31:0] y;
            r.redirect      = 1'b0;
            r.redirect_line = '0;
            r.written_value = '0;
            r.status        = STATUS_CONTINUE;
            case (op)
                OP_NONE:
                begin
                end
                OP_ADD, OP_SUB, OP_MUL, OP_SLT:
                begin
                    if (is_reserved(d) || is_reserved(s) || is_reserved(t))
                    begin
                        r.status = STATUS_ERROR;
                    end
                    else
                    begin
                        x = read_reg(s);
                        y = read_reg(t);
                        case (op)
                            OP_ADD:  a = x + y;
                            OP_SUB:  a = x - y;
                            OP_MUL:  a = x * y;
                            default: a = ($signed(x) < $signed(y)) ? 32'd1 : 32'd0;
                        endcase
                        r.written_value = write_reg(d, a);
                    end
                end
                OP_ADDI:
                begin
                    if (is_reserved(d) || is_reserved(s))
                        r.status = STATUS_ERROR;
                    else
                        r.written_value = write_reg(d, read_reg(s) + imm);
                end
                OP_LA:
                begin
                    if (is_reserved(d) || lab == 12'd0)
                        r.status = STATUS_ERROR;
                    else
                        r.written_value = write_reg(d, {20'd0, lab});
                end
                OP_LW_LABEL, OP_SW_LABEL:
                begin
                    a = {20'd0, lab};
                    if (is_reserved(d) || lab == 12'd0 || !word_ok(a))
                    begin
                        r.status = STATUS_ERROR;
                    end
                    else if (op == OP_LW_LABEL)
                    begin
                        r.written_value = write_reg(d, mem[a / 4]);
                    end
                    else
                    begin
                        r.written_value = read_reg(d);
                        mem[a / 4] = r.written_value;
                    end
                end
                OP_LW_OFFSET, OP_SW_OFFSET:
                begin
                    a = imm + read_reg(s);
                    if (is_reserved(d) || is_reserved(s) || imm[1:0] != 2'b00 || !word_ok(a))
                    begin
                        r.status = STATUS_ERROR;
                    end
                    else if (op == OP_LW_OFFSET)
                    begin
                        r.written_value = write_reg(d, mem[a / 4]);
                    end
                    else
                    begin
                        r.written_value = read_reg(d);
                        mem[a / 4] = r.written_value;
                    end
                end
                OP_BNE:
                begin
                    if (is_reserved(d) || is_reserved(s) || tgt == 12'd0)
                    begin
                        r.status = STATUS_ERROR;
                    end
                    else if (read_reg(d) != read_reg(s))
                    begin
                        r.redirect      = 1'b1;
                        r.redirect_line = tgt;
                    end
                end
                OP_J:
                begin
                    if (tgt == 12'd0)
                    begin
                        r.status = STATUS_ERROR;
                    end
                    else
                    begin
                        r.redirect      = 1'b1;
                        r.redirect_line = tgt;
                    end
                end
                OP_HALT:
                begin
                    r.status = STATUS_HALT;
                end
                default:
                begin
                    r.status = STATUS_ERROR;
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [3:0] op, logic [4:0] d, logic [4:0] s,
                                   logic [4:0] t, logic [31:0] imm,
                                   logic [11:0] tgt, logic [11:0] lab);
            result_t predicted;
            predicted = execute_instruction(op, d, s, t, imm, tgt, lab);
            expected_results.insert(expected_results.size(), predicted);
        endfunction

        function void check_result(logic redirect, logic [11:0] line, logic [31:0] value,
                                   logic [1:0] status);
            result_t want;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: redirect %0b line %0d value %h status %0d",
                             redirect, line, value, status);
                return;
            end
            want = expected_results.pop_front();
            if (redirect !== want.redirect || line !== want.redirect_line ||
                value !== want.written_value || status !== want.status)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("mismatch: expected redirect %0b line %0d value %h status %0d",
                             want.redirect, want.redirect_line, want.written_value,
                             want.status);
                    $display("          got redirect %0b line %0d value %h status %0d",
                             redirect, line, value, status);
                end
            end
        endfunction

    endclass

endpackage

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench that drives random instruction streams through the execute unit.
module tb_top;

    import mseu_pkg::*;
    import exec_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 1350;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               instr_valid = 1'b0;
    logic               instr_stall;
    logic [3:0]         operation = '0;
    logic [4:0]         dest_reg = '0;
    logic [4:0]         source_reg = '0;
    logic [4:0]         second_reg = '0;
    logic signed [31:0] immediate = '0;
    logic [11:0]        branch_target = '0;
    logic [11:0]        label_address = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic               redirect;
    logic [11:0]        redirect_line;
    logic signed [31:0] written_value;
    logic [1:0]         status;

    exec_scoreboard scoreboard;
    bit             quiet_sender = 1'b0;
    bit             quiet_receiver = 1'b0;
    int unsigned    sent_count = 0;
    int unsigned    result_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mips_subset_execute_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .instr_valid   (instr_valid),
        .instr_stall   (instr_stall),
        .operation     (operation),
        .dest_reg      (dest_reg),
        .source_reg    (source_reg),
        .second_reg    (second_reg),
        .immediate     (immediate),
        .branch_target (branch_target),
        .label_address (label_address),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .redirect      (redirect),
        .redirect_line (redirect_line),
        .written_value (written_value),
        .status        (status)
    );

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // Mostly usable registers, now and then register zero or a reserved one.
    function automatic logic [4:0] pick_reg();
        int k;
        int v;
        k = $urandom_range(0, 99);
        if (k < 2)
            return REG_AT;
        if (k < 3)
            return REG_K0;
        if (k < 4)
            return REG_K1;
        if (k < 8)
            return 5'd0;
        v = $urandom_range(2, 29);
        if (v >= 26)
            v += 2;
        return v[4:0];
    endfunction

    // Word addresses cluster at both ends of memory so loads see earlier stores.
    function automatic logic [31:0] pick_address();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return $urandom_range(0, 15) * 4;
        if (k < 8)
            return (MEM_WORDS - 16 + $urandom_range(0, 15)) * 4;
        return $urandom_range(0, MEM_WORDS - 1) * 4;
    endfunction

    task automatic send_request(input logic [3:0] op, input logic [4:0] d, input logic [4:0] s,
                                input logic [4:0] t, input logic [31:0] imm,
                                input logic [11:0] tgt, input logic [11:0] lab);
        int gap;
        gap = draw_gap(quiet_sender);
        if (gap > 0)
        begin
            instr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_valid   <= 1'b1;
        operation     <= op;
        dest_reg      <= d;
        source_reg    <= s;
        second_reg    <= t;
        immediate     <= imm;
        branch_target <= tgt;
        label_address <= lab;
        do
            @(posedge clk);
        while (instr_stall !== 1'b0);
        scoreboard.note_request(op, d, s, t, imm, tgt, lab);
        sent_count++;
        if (sent_count % 50 == 0)
            quiet_sender = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_random_request();
        logic [3:0]  op;
        logic [4:0]  d;
        logic [4:0]  s;
        logic [4:0]  t;
        logic [31:0] imm;
        logic [11:0] tgt;
        logic [11:0] lab;
        int          k;
        int          w;
        // Fields that the operation ignores still carry random values.
        d   = 5'($urandom_range(0, 31));
        s   = 5'($urandom_range(0, 31));
        t   = 5'($urandom_range(0, 31));
        imm = $urandom();
        tgt = 12'($urandom_range(0, 4095));
        lab = 12'($urandom_range(0, 4095));
        w   = $urandom_range(0, 99);
        k   = $urandom_range(0, 9);
        if (w < 3)
        begin
            op = OP_NONE;
        end
        else if (w < 36)
        begin
            if (w < 13)
                op = OP_ADD;
            else if (w < 21)
                op = OP_SUB;
            else if (w < 28)
                op = OP_MUL;
            else
                op = OP_SLT;
            d = pick_reg();
            s = pick_reg();
            t = pick_reg();
        end
        else if (w < 48)
        begin
            op = OP_ADDI;
            d  = pick_reg();
            s  = pick_reg();
            if (k < 7)
                imm = $urandom_range(0, 64) - 32;
            else if (k < 8)
                imm = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            else if (k < 9)
                imm = ($urandom_range(0, 64) - 32) * 4;
        end
        else if (w < 56)
        begin
            op = OP_LA;
            d  = pick_reg();
            if (k < 3)
                lab = 12'(pick_address());
            else if (k == 9)
                lab = 12'd0;
        end
        else if (w < 72)
        begin
            op = (w < 64) ? OP_LW_LABEL : OP_SW_LABEL;
            d  = pick_reg();
            if (k < 8)
                lab = 12'(pick_address());
            else if (k == 9)
                lab = 12'd0;
        end
        else if (w < 90)
        begin
            op = (w < 81) ? OP_LW_OFFSET : OP_SW_OFFSET;
            d  = pick_reg();
            s  = pick_reg();
            // Aim the offset at a chosen word through the current base value.
            if (k < 7)
                imm = pick_address() - scoreboard.read_reg(s);
            else if (k < 9)
                imm = ($urandom_range(0, 64) - 32) * 4;
        end
        else if (w < 97)
        begin
            op = (w < 95) ? OP_BNE : OP_J;
            d  = pick_reg();
            s  = (k < 4) ? d : pick_reg();
            if ($urandom_range(0, 19) == 0)
                tgt = 12'd0;
        end
        else if (w < 98)
        begin
            op = OP_HALT;
        end
        else
        begin
            op = (w == 98) ? OP_INVALID : OP_UNDEFINED;
        end
        send_request(op, d, s, t, imm, tgt, lab);
    endtask

    initial
    begin
        scoreboard = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_NONE, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 12'hfff, 12'hfff);
        send_request(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'h7fff_ffff, 12'd0, 12'd0);
        send_request(OP_ADDI, 5'd3, 5'd0, 5'd0, 32'h8000_0000, 12'd0, 12'd0);
        send_request(OP_ADD, 5'd4, 5'd2, 5'd2, 32'd0, 12'd0, 12'd0);
        send_request(OP_SUB, 5'd5, 5'd3, 5'd2, 32'd0, 12'd0, 12'd0);
        send_request(OP_MUL, 5'd6, 5'd2, 5'd3, 32'd0, 12'd0, 12'd0);
        send_request(OP_SLT, 5'd7, 5'd3, 5'd2, 32'd0, 12'd0, 12'd0);
        // A write to register zero is dropped and reports a zero value.
        send_request(OP_SLT, 5'd0, 5'd3, 5'd2, 32'd0, 12'd0, 12'd0);
        send_request(OP_ADD, 5'd31, 5'd1, 5'd2, 32'd0, 12'd0, 12'd0);
        send_request(OP_ADDI, 5'd26, 5'd2, 5'd0, 32'd4, 12'd0, 12'd0);
        send_request(OP_LA, 5'd8, 5'd0, 5'd0, 32'd0, 12'd0, 12'd0);
        send_request(OP_LA, 5'd8, 5'd0, 5'd0, 32'd0, 12'd0, 12'hffc);
        send_request(OP_SW_LABEL, 5'd2, 5'd0, 5'd0, 32'd0, 12'd0, 12'hffc);
        send_request(OP_LW_LABEL, 5'd9, 5'd0, 5'd0, 32'd0, 12'd0, 12'hffc);
        send_request(OP_LW_LABEL, 5'd9, 5'd0, 5'd0, 32'd0, 12'd0, 12'h002);
        send_request(OP_SW_OFFSET, 5'd3, 5'd8, 5'd0, -32'sd4, 12'd0, 12'd0);
        send_request(OP_LW_OFFSET, 5'd10, 5'd8, 5'd0, -32'sd4, 12'd0, 12'd0);
        // One word past the end of memory.
        send_request(OP_LW_OFFSET, 5'd10, 5'd8, 5'd0, 32'd4, 12'd0, 12'd0);
        send_request(OP_LW_OFFSET, 5'd10, 5'd8, 5'd0, 32'd2, 12'd0, 12'd0);
        send_request(OP_SW_OFFSET, 5'd27, 5'd0, 5'd0, 32'd0, 12'd0, 12'd0);
        send_request(OP_BNE, 5'd2, 5'd3, 5'd0, 32'd0, 12'hfff, 12'd0);
        send_request(OP_BNE, 5'd2, 5'd2, 5'd0, 32'd0, 12'd5, 12'd0);
        send_request(OP_BNE, 5'd2, 5'd3, 5'd0, 32'd0, 12'd0, 12'd0);
        send_request(OP_J, 5'd0, 5'd0, 5'd0, 32'd0, 12'd0, 12'd0);
        send_request(OP_J, 5'd0, 5'd0, 5'd0, 32'd0, 12'hfff, 12'd0);
        send_request(OP_HALT, 5'd0, 5'd0, 5'd0, 32'd0, 12'd0, 12'd0);
        send_request(OP_INVALID, 5'd2, 5'd2, 5'd2, 32'd0, 12'd1, 12'd4);
        send_request(OP_UNDEFINED, 5'd2, 5'd2, 5'd2, 32'd0, 12'd1, 12'd4);

        repeat (RANDOM_ITEMS)
            send_random_request();
        instr_valid <= 1'b0;

        while (scoreboard.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (scoreboard.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: random stall stretches, one result taken per handshake.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(quiet_receiver);
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(result_valid === 1'b1 && result_stall == 1'b0));
            scoreboard.check_result(redirect, redirect_line, written_value, status);
            result_count++;
            if (result_count % 40 == 0)
                quiet_receiver = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/mseu_pkg.sv
rtl/mseu_ram.sv
rtl/mips_subset_execute_unit.sv
test/exec_scoreboard_pkg.sv
test/tb_top.sv
